### rtl/jjs_pkg.sv
// ----------------------------------------------------------------------------
// jjs_pkg: shared types and constants of the joystick joint jog selector
// Reset values, field widths, register indexes and the per-item decision.
// ----------------------------------------------------------------------------
package jjs_pkg;

  localparam int AXIS_W   = 12;
  localparam int TIME_W   = 32;
  localparam int COOL_W   = 16;
  localparam int ANGLE_W  = 8;
  localparam int JOINT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_JOINTS = 6;

  localparam logic [AXIS_W-1:0]  RST_LOW       = AXIS_W'(1200);
  localparam logic [AXIS_W-1:0]  RST_HIGH      = AXIS_W'(2800);
  localparam logic [COOL_W-1:0]  RST_COOLDOWN  = COOL_W'(300);
  localparam logic [ANGLE_W-1:0] RST_ANGLE_MAX = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] RST_ANGLE     = ANGLE_W'(90);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD  = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1,
    REG_COOLDOWN_MS    = 2'd2,
    REG_ANGLE_MAX      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [AXIS_W-1:0]  low_threshold;
    logic [AXIS_W-1:0]  high_threshold;
    logic [COOL_W-1:0]  cooldown_ms;
    logic [ANGLE_W-1:0] angle_max;
  } cfg_t;

  // Decision for one item, apart from the next joint index
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               switched;
    logic               armed;
  } step_t;

endpackage

### rtl/jjs_if.sv
// ----------------------------------------------------------------------------
// jjs_in_if / jjs_out_if: sample and result channels
// Valid/ready channels carrying one joystick sample or one jog result.
// ----------------------------------------------------------------------------
interface jjs_in_if;
  import jjs_pkg::*;

  logic              valid;
  logic              ready;
  logic [AXIS_W-1:0] joy_x;
  logic [AXIS_W-1:0] joy_y;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output joy_x, output joy_y, output now_ms, input ready);
  modport sink   (input valid, input joy_x, input joy_y, input now_ms, output ready);
endinterface

interface jjs_out_if;
  import jjs_pkg::*;

  logic               valid;
  logic               ready;
  logic [JOINT_W-1:0] moved_joint;
  logic [ANGLE_W-1:0] moved_angle;
  logic [JOINT_W-1:0] selected_joint;
  logic               joint_switched;

  modport source (output valid, output moved_joint, output moved_angle,
                  output selected_joint, output joint_switched, input ready);
  modport sink   (input valid, input moved_joint, input moved_angle,
                  input selected_joint, input joint_switched, output ready);
endinterface

### rtl/jjs_step.sv
// ----------------------------------------------------------------------------
// jjs_step: jog and joint-select decision for one sample
// Clamped angle update of the selected joint and the switching decision.
// ----------------------------------------------------------------------------
module jjs_step #(
  parameter int JOINTS = jjs_pkg::DEF_JOINTS,
  parameter int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
  input  jjs_pkg::cfg_t                  cfg,
  input  logic [jjs_pkg::AXIS_W-1:0]     joy_x,
  input  logic [jjs_pkg::AXIS_W-1:0]     joy_y,
  input  logic [jjs_pkg::TIME_W-1:0]     now_ms,
  input  logic [jjs_pkg::ANGLE_W-1:0]    angle,
  input  logic [JW-1:0]                  joint,
  input  logic                           armed,
  input  logic [jjs_pkg::TIME_W-1:0]     last_switch,
  output jjs_pkg::step_t                 step,
  output logic [JW-1:0]                  joint_nxt
);
  import jjs_pkg::*;

  logic               x_low, x_high, y_low, y_high, y_mid;
  logic [ANGLE_W:0]   jog;
  logic [ANGLE_W-1:0] angle_new;
  logic [TIME_W-1:0]  elapsed;
  logic               armed_mid, may_switch;
  logic               switched;
  logic [JW-1:0]      joint_up, joint_dn;

  assign x_low  = joy_x < cfg.low_threshold;
  assign x_high = joy_x > cfg.high_threshold;
  assign y_low  = joy_y < cfg.low_threshold;
  assign y_high = joy_y > cfg.high_threshold;
  assign y_mid  = (joy_y > cfg.low_threshold) && (joy_y < cfg.high_threshold);

  // Both jog directions at once cancel out
  always_comb begin
    jog = {1'b0, angle};
    if (x_high && !x_low) begin
      jog = {1'b0, angle} + (ANGLE_W+1)'(1);
    end else if (x_low && !x_high && angle != '0) begin
      jog = {1'b0, angle} - (ANGLE_W+1)'(1);
    end
  end

  assign angle_new = (jog > {1'b0, cfg.angle_max}) ? cfg.angle_max : jog[ANGLE_W-1:0];

  assign elapsed    = now_ms - last_switch;
  assign armed_mid  = armed || y_mid;
  assign may_switch = armed_mid && (elapsed > {{(TIME_W-COOL_W){1'b0}}, cfg.cooldown_ms});

  assign joint_up = (joint == JW'(JOINTS-1)) ? '0 : joint + JW'(1);
  assign joint_dn = (joint == '0) ? JW'(JOINTS-1) : joint - JW'(1);

  // High wins when both directions hold
  always_comb begin
    joint_nxt = joint;
    switched  = 1'b0;
    if (may_switch && y_high) begin
      joint_nxt = joint_up;
      switched  = 1'b1;
    end else if (may_switch && y_low) begin
      joint_nxt = joint_dn;
      switched  = 1'b1;
    end
  end

  assign step = '{angle: angle_new, switched: switched, armed: armed_mid && !switched};

endmodule

### rtl/joystick_joint_jog_selector_unit.sv
// ----------------------------------------------------------------------------
// joystick_joint_jog_selector_unit: joystick jog and joint selection
// Jogs the selected joint's angle by X and steps the selection by Y.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | joy_x, joy_y, now_ms
//  out_ch   | out | valid/ready  | moved_joint, moved_angle, selected_joint,
//           |     |              | joint_switched
//  cfg_*    | in  | write enable | cfg_index, cfg_wdata
//
// One item per cycle sustained while the result is not stalled; a result passes
// through the sample register, then the result register. The joint state updates
// as an item moves from the sample register into the result register.
// Reset is synchronous; all angles return to 90.
// A stalled result holds; the sample register keeps accepting while it is free.
// ----------------------------------------------------------------------------
module joystick_joint_jog_selector_unit #(
  parameter int JOINTS = jjs_pkg::DEF_JOINTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  jjs_in_if.sink                           in_ch,
  jjs_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [jjs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jjs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import jjs_pkg::*;

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  cfg_t               cfg_r;
  logic               in_valid_r;
  logic [AXIS_W-1:0]  joy_x_r, joy_y_r;
  logic [TIME_W-1:0]  now_ms_r;

  logic [ANGLE_W-1:0] angles_r [JOINTS];
  logic [JW-1:0]      joint_r, joint_nxt;
  logic               armed_r;
  logic [TIME_W-1:0]  last_switch_r;

  logic               out_valid_r;
  logic [JOINT_W-1:0] moved_joint_r, selected_joint_r;
  logic [ANGLE_W-1:0] moved_angle_r;
  logic               switched_r;

  logic               advance;
  step_t              step;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold  <= RST_LOW;
      cfg_r.high_threshold <= RST_HIGH;
      cfg_r.cooldown_ms    <= RST_COOLDOWN;
      cfg_r.angle_max      <= RST_ANGLE_MAX;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_THRESHOLD:  cfg_r.low_threshold  <= cfg_wdata[AXIS_W-1:0];
        REG_HIGH_THRESHOLD: cfg_r.high_threshold <= cfg_wdata[AXIS_W-1:0];
        REG_COOLDOWN_MS:    cfg_r.cooldown_ms    <= cfg_wdata[COOL_W-1:0];
        REG_ANGLE_MAX:      cfg_r.angle_max      <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      joy_x_r  <= in_ch.joy_x;
      joy_y_r  <= in_ch.joy_y;
      now_ms_r <= in_ch.now_ms;
    end
  end

  jjs_step #(.JOINTS(JOINTS), .JW(JW)) u_step (
    .cfg         (cfg_r),
    .joy_x       (joy_x_r),
    .joy_y       (joy_y_r),
    .now_ms      (now_ms_r),
    .angle       (angles_r[joint_r]),
    .joint       (joint_r),
    .armed       (armed_r),
    .last_switch (last_switch_r),
    .step        (step),
    .joint_nxt   (joint_nxt)
  );

  // Joint state, advanced once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINTS; i++) begin
        angles_r[i] <= RST_ANGLE;
      end
      joint_r       <= '0;
      armed_r       <= 1'b1;
      last_switch_r <= '0;
    end else if (advance) begin
      angles_r[joint_r] <= step.angle;
      joint_r           <= joint_nxt;
      armed_r           <= step.armed;
      if (step.switched) begin
        last_switch_r <= now_ms_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      moved_joint_r    <= JOINT_W'(joint_r);
      moved_angle_r    <= step.angle;
      selected_joint_r <= JOINT_W'(joint_nxt);
      switched_r       <= step.switched;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.moved_joint    = moved_joint_r;
  assign out_ch.moved_angle    = moved_angle_r;
  assign out_ch.selected_joint = selected_joint_r;
  assign out_ch.joint_switched = switched_r;

endmodule
